[design/rpv_pkg.sv]
// Shared types, constants and helper functions of the ring polygon vertex generator.
`timescale 1ns / 1ps

package rpv_pkg;

    // Limits and field widths
    localparam int MAX_CORNERS   = 64;
    localparam int CNT_W         = 7;
    localparam int IDX_W         = 6;
    localparam int COORD_W       = 16;
    localparam int QUAD_W        = 7;
    localparam int RAD_W         = 15;
    localparam int CFG_IDX_W     = 2;
    localparam int STEP_W        = 4;

    // Datapath widths
    localparam int R2_W          = 18;
    localparam int TRIG_W        = 33;
    localparam int PROD_W        = R2_W + TRIG_W;
    localparam int NUM_W         = 40;
    localparam int DIGIT_W       = 4;
    localparam int DIV_DIGITS    = NUM_W / DIGIT_W;
    localparam int ANGLE_W       = 31;
    localparam int CORDIC_STEPS  = 16;
    localparam int ROUND_SHIFT   = 31;

    localparam logic [CNT_W-1:0]         MIN_CORNERS    = 7'd3;
    localparam logic [CNT_W-1:0]         CORNER_STEP    = 7'd4;
    localparam logic [ANGLE_W-1:0]       HALF_PI_Q30    = 31'd1686629713;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN    = 33'sd652032874;
    localparam logic [RAD_W-1:0]         RADIUS_RESET   = 15'd2048;
    localparam logic [RAD_W-1:0]         THICK_RESET    = 15'd410;
    localparam logic signed [COORD_W-1:0] COORD_MAX     = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN     = 16'sh8000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS    = 2'd0,
        REG_THICKNESS = 2'd1
    } t_reg_idx;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MULT,
        ST_DIVIDE,
        ST_ROTATE,
        ST_SCALE,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic              idle;
        logic              load;
        logic              rem_sub;
        logic              num_load;
        logic              div_step;
        logic              rot_step;
        logic              rot_first;
        logic [STEP_W-1:0] step_idx;
        logic              mul_en;
        logic              out_load;
        logic              next_corner;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic req_accept;
        logic req_short;
        logic rem_ge_n;
        logic last;
        logic out_free;
    } t_status;

    // Arctangent table, Q2.30 radians
    function automatic logic signed [TRIG_W-1:0] atan_q30(input logic [STEP_W-1:0] k);
        logic signed [TRIG_W-1:0] v;
        unique case (k)
            4'd0:    v = 33'sh03243F6A8;
            4'd1:    v = 33'sh01DAC6705;
            4'd2:    v = 33'sh00FADBAFC;
            4'd3:    v = 33'sh007F56EA6;
            4'd4:    v = 33'sh003FEAB76;
            4'd5:    v = 33'sh001FFD55B;
            4'd6:    v = 33'sh000FFFAAA;
            4'd7:    v = 33'sh0007FFF55;
            4'd8:    v = 33'sh0003FFFEA;
            4'd9:    v = 33'sh0001FFFFD;
            4'd10:   v = 33'sh0000FFFFF;
            4'd11:   v = 33'sh00007FFFF;
            4'd12:   v = 33'sh00003FFFF;
            4'd13:   v = 33'sh00001FFFF;
            4'd14:   v = 33'sh00000FFFF;
            default: v = 33'sh000007FFF;
        endcase
        return v;
    endfunction

endpackage

[design/rpv_if.sv]
// Request, result and configuration channel interfaces of the ring polygon vertex generator.
`timescale 1ns / 1ps

interface rpv_req_if;
    logic                      valid;
    logic                      ready;
    logic [rpv_pkg::CNT_W-1:0] vert_count;

    modport source (output valid, output vert_count, input ready);
    modport sink   (input valid, input vert_count, output ready);
endinterface

interface rpv_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [rpv_pkg::COORD_W-1:0] inner_x;
    logic signed [rpv_pkg::COORD_W-1:0] inner_y;
    logic signed [rpv_pkg::COORD_W-1:0] outer_x;
    logic signed [rpv_pkg::COORD_W-1:0] outer_y;
    logic [rpv_pkg::QUAD_W-1:0]         quad_a;
    logic [rpv_pkg::QUAD_W-1:0]         quad_b;
    logic [rpv_pkg::QUAD_W-1:0]         quad_c;
    logic [rpv_pkg::QUAD_W-1:0]         quad_d;
    logic                               last_corner;

    modport source (output valid, output inner_x, output inner_y, output outer_x,
                    output outer_y, output quad_a, output quad_b, output quad_c,
                    output quad_d, output last_corner, input ready);
    modport sink   (input valid, input inner_x, input inner_y, input outer_x,
                    input outer_y, input quad_a, input quad_b, input quad_c,
                    input quad_d, input last_corner, output ready);
endinterface

interface rpv_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rpv_pkg::CFG_IDX_W-1:0] index;
    logic [rpv_pkg::RAD_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/rpv_ctrl.sv]
// Controller state machine: sequences reduction, division, rotation, scaling and emit per corner.
`timescale 1ns / 1ps

module rpv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rpv_pkg::t_status i_status,
    output rpv_pkg::t_cmd    o_cmd
);

    rpv_pkg::t_state                 r_state, n_state;
    logic [rpv_pkg::STEP_W-1:0]      r_cnt, n_cnt;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpv_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        o_cmd            = '0;
        o_cmd.step_idx   = r_cnt;
        unique case (r_state)
            rpv_pkg::ST_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_status.req_accept && !i_status.req_short) begin
                    o_cmd.load = 1'b1;
                    n_state    = rpv_pkg::ST_MULT;
                end
            end
            rpv_pkg::ST_REDUCE: begin
                // Subtract n until the remainder drops below n
                if (i_status.rem_ge_n) begin
                    o_cmd.rem_sub = 1'b1;
                end else begin
                    n_state = rpv_pkg::ST_MULT;
                end
            end
            rpv_pkg::ST_MULT: begin
                o_cmd.num_load = 1'b1;
                n_cnt          = '0;
                n_state        = rpv_pkg::ST_DIVIDE;
            end
            rpv_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == rpv_pkg::STEP_W'(rpv_pkg::DIV_DIGITS - 1)) begin
                    n_cnt   = '0;
                    n_state = rpv_pkg::ST_ROTATE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rpv_pkg::ST_ROTATE: begin
                o_cmd.rot_step  = 1'b1;
                o_cmd.rot_first = (r_cnt == '0);
                if (r_cnt == rpv_pkg::STEP_W'(rpv_pkg::CORDIC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = rpv_pkg::ST_SCALE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rpv_pkg::ST_SCALE: begin
                // Four products, then a final step that rounds the last
                o_cmd.mul_en = (r_cnt != rpv_pkg::STEP_W'(4));
                if (r_cnt == rpv_pkg::STEP_W'(4)) begin
                    n_cnt   = '0;
                    n_state = rpv_pkg::ST_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            rpv_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_status.last) begin
                        n_state = rpv_pkg::ST_IDLE;
                    end else begin
                        o_cmd.next_corner = 1'b1;
                        n_state           = rpv_pkg::ST_REDUCE;
                    end
                end
            end
            default: begin
                n_state = rpv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/rpv_dp.sv]
// Datapath: configuration registers, angle division, CORDIC, radius scaling and result register.
`timescale 1ns / 1ps

module rpv_dp #(
    parameter int MAX_CORNERS = rpv_pkg::MAX_CORNERS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rpv_pkg::t_cmd    i_cmd,
    output rpv_pkg::t_status o_status,
    rpv_req_if.sink          req,
    rpv_rsp_if.source        rsp,
    rpv_cfg_if.sink          cfg
);

    localparam logic [rpv_pkg::CNT_W-1:0] N_LIMIT = rpv_pkg::CNT_W'(MAX_CORNERS);
    localparam int NW = rpv_pkg::NUM_W;
    localparam int TW = rpv_pkg::TRIG_W;

    logic [rpv_pkg::RAD_W-1:0]        r_radius;
    logic [rpv_pkg::RAD_W-1:0]        r_thick;
    logic [rpv_pkg::CNT_W-1:0]        r_n;
    logic [rpv_pkg::IDX_W-1:0]        r_i;
    logic [rpv_pkg::CNT_W-1:0]        r_rem;
    logic [1:0]                       r_quad;
    logic [NW-1:0]                    r_num, n_num;
    logic [rpv_pkg::CNT_W-1:0]        r_drem, n_drem;
    logic signed [TW-1:0]             r_x, r_y, r_z;
    logic signed [rpv_pkg::PROD_W-1:0] r_prod;
    logic [1:0]                       r_prod_idx;
    logic                             r_prod_vld;
    logic signed [rpv_pkg::COORD_W-1:0] r_coord [4];
    logic                             r_out_vld;

    logic [rpv_pkg::CNT_W-1:0]        w_n_clamp;
    logic [rpv_pkg::IDX_W-1:0]        w_nx;
    logic                             w_last;
    logic signed [rpv_pkg::R2_W-1:0]  w_ri2, w_ro2, w_r2;
    logic signed [TW-1:0]             w_c, w_s, w_trig;
    logic signed [TW-1:0]             w_xi, w_yi, w_zi, w_dx, w_dy;
    logic signed [rpv_pkg::PROD_W-1:0] w_prod;

    // Configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= rpv_pkg::RADIUS_RESET;
            r_thick  <= rpv_pkg::THICK_RESET;
        end else if (cfg.valid && cfg.ready) begin
            unique case (cfg.index)
                rpv_pkg::REG_RADIUS:    r_radius <= cfg.data;
                rpv_pkg::REG_THICKNESS: r_thick  <= cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Request intake and status
    assign req.ready = i_cmd.idle;
    assign w_n_clamp = (req.vert_count > N_LIMIT) ? N_LIMIT : req.vert_count;
    assign w_last    = ({1'b0, r_i} == (r_n - 1'b1));
    assign w_nx      = w_last ? '0 : (r_i + 1'b1);

    assign o_status.req_accept = req.valid && req.ready;
    assign o_status.req_short  = (req.vert_count < rpv_pkg::MIN_CORNERS);
    assign o_status.rem_ge_n   = (r_rem >= r_n);
    assign o_status.last       = w_last;
    assign o_status.out_free   = !r_out_vld || rsp.ready;

    // Corner counter, remainder of 4i by n, and quadrant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= rpv_pkg::MIN_CORNERS;
            r_i    <= '0;
            r_rem  <= '0;
            r_quad <= '0;
        end else if (i_cmd.load) begin
            r_n    <= w_n_clamp;
            r_i    <= '0;
            r_rem  <= '0;
            r_quad <= '0;
        end else if (i_cmd.rem_sub) begin
            r_rem  <= r_rem - r_n;
            r_quad <= r_quad + 1'b1;
        end else if (i_cmd.next_corner) begin
            r_i    <= r_i + 1'b1;
            r_rem  <= r_rem + rpv_pkg::CORNER_STEP;
        end
    end

    // Divide one 4-bit digit of the numerator by n
    always_comb begin
        logic [rpv_pkg::CNT_W:0]    part;
        logic [rpv_pkg::DIGIT_W-1:0] qd;
        part = {1'b0, r_drem};
        qd   = '0;
        for (int j = rpv_pkg::DIGIT_W - 1; j >= 0; j--) begin
            part = {part[rpv_pkg::CNT_W-1:0], r_num[NW - rpv_pkg::DIGIT_W + j]};
            if (part >= {1'b0, r_n}) begin
                part  = part - {1'b0, r_n};
                qd[j] = 1'b1;
            end
        end
        n_num  = {r_num[NW-rpv_pkg::DIGIT_W-1:0], qd};
        n_drem = part[rpv_pkg::CNT_W-1:0];
    end

    // Numerator load, then long division in place: quotient shifts in from the bottom
    always_ff @(posedge i_clk) begin
        if (i_cmd.num_load) begin
            r_num  <= NW'(r_rem) * NW'(rpv_pkg::HALF_PI_Q30) + NW'(r_n[rpv_pkg::CNT_W-1:1]);
            r_drem <= '0;
        end else if (i_cmd.div_step) begin
            r_num  <= n_num;
            r_drem <= n_drem;
        end
    end

    // CORDIC rotation, one step a cycle
    assign w_xi = i_cmd.rot_first ? rpv_pkg::CORDIC_GAIN : r_x;
    assign w_yi = i_cmd.rot_first ? '0 : r_y;
    assign w_zi = i_cmd.rot_first ? $signed({2'b00, r_num[rpv_pkg::ANGLE_W-1:0]}) : r_z;
    assign w_dx = w_yi >>> i_cmd.step_idx;
    assign w_dy = w_xi >>> i_cmd.step_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rot_step) begin
            if (!w_zi[TW-1]) begin
                r_x <= w_xi - w_dx;
                r_y <= w_yi + w_dy;
                r_z <= w_zi - rpv_pkg::atan_q30(i_cmd.step_idx);
            end else begin
                r_x <= w_xi + w_dx;
                r_y <= w_yi - w_dy;
                r_z <= w_zi + rpv_pkg::atan_q30(i_cmd.step_idx);
            end
        end
    end

    // Map the first-quadrant result to the corner's quadrant
    always_comb begin
        unique case (r_quad)
            2'd0: begin w_c = r_x;  w_s = r_y;  end
            2'd1: begin w_c = -r_y; w_s = r_x;  end
            2'd2: begin w_c = -r_x; w_s = -r_y; end
            default: begin w_c = r_y; w_s = -r_x; end
        endcase
    end

    // Doubled radii, exact in Q5.12
    assign w_ri2 = $signed({2'b00, r_radius, 1'b0}) - $signed({3'b000, r_thick});
    assign w_ro2 = $signed({2'b00, r_radius, 1'b0}) + $signed({3'b000, r_thick});

    // Scale: inner x, inner y, outer x, outer y through one shared multiplier
    assign w_r2   = i_cmd.step_idx[1] ? w_ro2 : w_ri2;
    assign w_trig = i_cmd.step_idx[0] ? w_s : w_c;
    assign w_prod = w_r2 * w_trig;

    localparam int PROD_W1 = rpv_pkg::PROD_W + 1;

    // Round half up by 2^31, then saturate to Q3.12
    function automatic logic signed [rpv_pkg::COORD_W-1:0] sat_q12(
        input logic signed [rpv_pkg::PROD_W-1:0] p
    );
        logic signed [rpv_pkg::PROD_W:0]                     sum;
        logic signed [rpv_pkg::PROD_W-rpv_pkg::ROUND_SHIFT:0] v;
        sum = $signed({p[rpv_pkg::PROD_W-1], p}) + (PROD_W1'(1) <<< (rpv_pkg::ROUND_SHIFT - 1));
        v   = sum[rpv_pkg::PROD_W:rpv_pkg::ROUND_SHIFT];
        if (v > $signed({{(rpv_pkg::PROD_W - rpv_pkg::ROUND_SHIFT - rpv_pkg::COORD_W + 1){1'b0}},
                         rpv_pkg::COORD_MAX})) begin
            return rpv_pkg::COORD_MAX;
        end else if (v < $signed({{(rpv_pkg::PROD_W - rpv_pkg::ROUND_SHIFT - rpv_pkg::COORD_W + 1){1'b1}},
                                  rpv_pkg::COORD_MIN})) begin
            return rpv_pkg::COORD_MIN;
        end
        return v[rpv_pkg::COORD_W-1:0];
    endfunction

    // Product register, then rounded coordinate store in the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod     <= w_prod;
            r_prod_idx <= i_cmd.step_idx[1:0];
        end
        if (r_prod_vld) begin
            r_coord[r_prod_idx] <= sat_q12(r_prod);
        end
    end

    // Result register: hold until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            rsp.inner_x     <= r_coord[0];
            rsp.inner_y     <= r_coord[1];
            rsp.outer_x     <= r_coord[2];
            rsp.outer_y     <= r_coord[3];
            rsp.quad_a      <= {r_i, 1'b0};
            rsp.quad_b      <= {r_i, 1'b1};
            rsp.quad_c      <= {w_nx, 1'b1};
            rsp.quad_d      <= {w_nx, 1'b0};
            rsp.last_corner <= w_last;
        end
    end

    assign rsp.valid = r_out_vld;

endmodule

[design/ring_polygon_vertex_generator_core.sv]
// Top level of the ring polygon vertex generator: controller, datapath and channel ports.
`timescale 1ns / 1ps

// A request carries a corner count n (below 3: no results; above MAX_CORNERS: clamped)
// and yields n results, one per corner, with the inner and outer ring points at angle
// 2*pi*i/n in saturated signed Q3.12 and the four quad indices. Requests are handled
// one at a time; a new request is taken once the last corner has been loaded into the
// result register. Each corner runs these steps in order, the last held by any result
// stall: reduce 4i modulo n, form the angle numerator, run the radix-16 angle divider
// (one 4-bit digit a cycle), iterate the shared CORDIC stage, form four products through
// the single shared radius multiplier and round the last, and load the result register.
// Configuration writes are accepted every cycle and must only be made while no request
// is in progress.
module ring_polygon_vertex_generator_core #(
    parameter int MAX_CORNERS = rpv_pkg::MAX_CORNERS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpv_req_if.sink   i_req,
    rpv_rsp_if.source o_rsp,
    rpv_cfg_if.sink   i_cfg
);

    rpv_pkg::t_cmd    w_cmd;
    rpv_pkg::t_status w_status;

    // Sequence the per-corner steps
    rpv_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Do the arithmetic and hold the result
    rpv_dp #(
        .MAX_CORNERS (MAX_CORNERS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .req      (i_req),
        .rsp      (o_rsp),
        .cfg      (i_cfg)
    );

endmodule

[design/rpv_checker.sv]
// Port-level checks of the ring polygon vertex generator, bound to the top level.
`timescale 1ns / 1ps

module rpv_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [rpv_pkg::CNT_W-1:0]          in_count,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [rpv_pkg::COORD_W-1:0] out_inner_x,
    input logic signed [rpv_pkg::COORD_W-1:0] out_outer_y,
    input logic [rpv_pkg::QUAD_W-1:0]         out_quad_a,
    input logic [rpv_pkg::QUAD_W-1:0]         out_quad_c,
    input logic [rpv_pkg::QUAD_W-1:0]         out_quad_d,
    input logic                               out_last
);

    // No result pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_inner_x) &&
            $stable(out_outer_y) && $stable(out_quad_a) && $stable(out_last))
        else $error("stalled result changed");

    // A request with corners closes the request port while it runs
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && (in_count >= rpv_pkg::MIN_CORNERS) |=> !in_ready)
        else $error("request port open during a request");

    // A request with too few corners leaves the block idle
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && (in_count < rpv_pkg::MIN_CORNERS) |=> in_ready)
        else $error("short request did not stay idle");

    // The last corner closes the ring onto corner zero
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_last |-> (out_quad_c == 7'd1) && (out_quad_d == 7'd0))
        else $error("last corner does not wrap to corner zero");

endmodule

bind ring_polygon_vertex_generator_core rpv_checker u_rpv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_req.valid),
    .in_ready    (i_req.ready),
    .in_count    (i_req.vert_count),
    .out_valid   (o_rsp.valid),
    .out_ready   (o_rsp.ready),
    .out_inner_x (o_rsp.inner_x),
    .out_outer_y (o_rsp.outer_y),
    .out_quad_a  (o_rsp.quad_a),
    .out_quad_c  (o_rsp.quad_c),
    .out_quad_d  (o_rsp.quad_d),
    .out_last    (o_rsp.last_corner)
);
